[sv/set_assoc_lru_cache_model_unit_macros.svh]
// Assertion macros used by the cache model unit.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_CHECK(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SALC_CHECK_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/salc_pkg.sv]
package salc_pkg;

  localparam int DEF_MAX_SETS  = 256;
  localparam int DEF_MAX_WAYS  = 8;
  localparam int DEF_ADDR_BITS = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int COUNT_W    = 48;
  localparam int OUT_WAY_W  = 3;
  localparam int RED_W      = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd5;
  localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RST  = 4'd6;
  localparam logic [CFG_DATA_W-1:0] WAYS_USED_RST   = 4'd4;

  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_WAYS_USED   = 2'd2
  } cfg_reg_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

[sv/set_assoc_lru_cache_model_unit.sv]
// Tag-only set-associative write-back cache with true LRU replacement. An access word
// is taken at every clock edge where start is high; busy stays low, so one access per
// cycle is sustained. Each access gives exactly one result word, held on the result
// ports with out_strobe high for one cycle. The accepting edge reads the set's row
// (tags, valid, dirty and LRU order) from the set memory, the cycle after it updates
// the row, and the next edge writes the row back and registers the result. A
// back-to-back access to the same set takes the updated row from a bypass register.
// The receiver cannot stall results.
// After reset no clearing pass is needed: a per-set flag marks rows never written,
// which read as empty with identity LRU order. Configuration is written through the
// cfg port, always ready, and should change only while no access is in flight.
`include "set_assoc_lru_cache_model_unit_macros.svh"

module set_assoc_lru_cache_model_unit #(
  parameter int MAX_SETS  = salc_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS  = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ADDR_BITS-1:0]             in_address,
  input  logic                             in_mode,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_strobe,
  output logic                             out_hit,
  output logic [salc_pkg::OUT_WAY_W-1:0]   out_way,
  output logic                             out_writeback,
  output logic [salc_pkg::COUNT_W-1:0]     out_access_count,
  output logic [salc_pkg::COUNT_W-1:0]     out_hit_count,
  output logic [salc_pkg::COUNT_W-1:0]     out_miss_count,
  output logic [salc_pkg::COUNT_W-1:0]     out_writeback_count
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);
  localparam int RW    = salc_pkg::RED_W;
  localparam int RECIP = (1 << RW) / MAX_SETS;
  localparam int CW    = salc_pkg::COUNT_W;

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [MAX_WAYS-1:0]                vld;
    logic [MAX_WAYS-1:0]                dty;
    logic [MAX_WAYS-1:0][WAY_W-1:0]     lru;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  logic [salc_pkg::CFG_DATA_W-1:0] offset_bits_r;
  logic [salc_pkg::CFG_DATA_W-1:0] index_bits_r;
  logic [salc_pkg::CFG_DATA_W-1:0] ways_used_r;

  logic                 accept;
  logic [ADDR_BITS-1:0] in_block;
  logic [RW-1:0]        in_masked;
  logic [2*RW:0]        red_prod;
  logic [RW:0]          red_quot;
  logic [RW:0]          red_qn;
  logic [RW:0]          red_rem;
  logic [RW:0]          red_set;
  logic [SET_W-1:0]     in_set;

  logic [MAX_SETS-1:0]  rowv_r;
  logic                 s_vld_r;
  logic                 s_wr_r;
  logic [ADDR_BITS-1:0] s_tag_r;
  logic [SET_W-1:0]     s_set_r;
  logic                 s_rowv_r;
  logic                 s_byp_r;
  row_t                 byp_row_r;

  logic [ROW_W-1:0]     ram_rdata;
  row_t                 ram_row;
  row_t                 rst_row;
  row_t                 cur_row;
  row_t                 new_row;

  logic [NW_W-1:0]      nways;
  logic                 hit;
  logic [WAY_W-1:0]     hit_way;
  logic                 found;
  logic [WAY_W-1:0]     free_way;
  logic                 vfound;
  logic [WAY_W-1:0]     vic_way;
  logic [WAY_W-1:0]     way;
  logic                 wb;
  logic                 qfound;
  logic [WAY_W-1:0]     qpos;

  logic [CW-1:0] acc_cnt_r, hit_cnt_r, miss_cnt_r, wb_cnt_r;
  logic [CW-1:0] acc_cnt_nxt, hit_cnt_nxt, miss_cnt_nxt, wb_cnt_nxt;

  logic                            out_strobe_r;
  logic                            out_hit_r;
  logic [salc_pkg::OUT_WAY_W-1:0]  out_way_r;
  logic                            out_wb_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Set number: block number masked to the index width, then reduced modulo the set count.
  assign in_block  = in_address >> offset_bits_r;
  assign in_masked = in_block[RW-1:0] & ((RW'(1) << index_bits_r) - RW'(1));
  assign red_prod  = (2*RW+1)'(in_masked) * (2*RW+1)'(RECIP);
  assign red_quot  = red_prod[2*RW:RW];
  assign red_qn    = (RW+1)'(red_quot * (RW+1)'(MAX_SETS));
  assign red_rem   = (RW+1)'(in_masked) - red_qn;
  assign red_set   = (red_rem >= (RW+1)'(MAX_SETS)) ? red_rem - (RW+1)'(MAX_SETS) : red_rem;
  assign in_set    = SET_W'(red_set);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= salc_pkg::OFFSET_BITS_RST;
      index_bits_r  <= salc_pkg::INDEX_BITS_RST;
      ways_used_r   <= salc_pkg::WAYS_USED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        salc_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_data;
        salc_pkg::REG_INDEX_BITS:  index_bits_r  <= cfg_data;
        salc_pkg::REG_WAYS_USED:   ways_used_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_ram (
    .clk  (clk),
    .we   (s_vld_r),
    .waddr(s_set_r),
    .wdata(new_row),
    .re   (accept),
    .raddr(in_set),
    .rdata(ram_rdata)
  );

  assign ram_row = row_t'(ram_rdata);

  always_comb begin
    if (ways_used_r == '0) begin
      nways = NW_W'(1);
    end else if (32'(ways_used_r) > MAX_WAYS) begin
      nways = NW_W'(MAX_WAYS);
    end else begin
      nways = NW_W'(ways_used_r);
    end
  end

  always_comb begin
    rst_row = '0;
    for (int p = 0; p < MAX_WAYS; p++) begin
      rst_row.lru[p] = WAY_W'(p);
    end
  end

  always_comb begin
    if (s_byp_r) begin
      cur_row = byp_row_r;
    end else if (s_rowv_r) begin
      cur_row = ram_row;
    end else begin
      cur_row = rst_row;
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    found    = 1'b0;
    free_way = '0;
    vfound   = 1'b0;
    vic_way  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && (NW_W'(w) < nways) && cur_row.vld[w] && (cur_row.tag[w] == s_tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!found && (NW_W'(w) < nways) && !cur_row.vld[w]) begin
        found    = 1'b1;
        free_way = WAY_W'(w);
      end
      if (!vfound && (NW_W'(cur_row.lru[w]) < nways)) begin
        vfound  = 1'b1;
        vic_way = cur_row.lru[w];
      end
    end
  end

  always_comb begin
    priority if (hit) begin
      way = hit_way;
    end else if (found) begin
      way = free_way;
    end else begin
      way = vic_way;
    end
  end

  assign wb = !hit && !found && cur_row.dty[vic_way];

  always_comb begin
    new_row = cur_row;
    qfound  = 1'b0;
    qpos    = WAY_W'(MAX_WAYS - 1);
    if (hit) begin
      if (s_wr_r == salc_pkg::MODE_WRITE) begin
        new_row.dty[way] = 1'b1;
      end
    end else begin
      new_row.tag[way] = s_tag_r;
      new_row.vld[way] = 1'b1;
      new_row.dty[way] = (s_wr_r == salc_pkg::MODE_WRITE);
    end
    for (int p = 0; p < MAX_WAYS; p++) begin
      if (!qfound && (cur_row.lru[p] == way)) begin
        qfound = 1'b1;
        qpos   = WAY_W'(p);
      end
    end
    for (int p = 0; p < MAX_WAYS; p++) begin
      if (WAY_W'(p) < qpos) begin
        new_row.lru[p] = cur_row.lru[p];
      end else if (p < MAX_WAYS - 1) begin
        new_row.lru[p] = cur_row.lru[(p + 1) % MAX_WAYS];
      end else begin
        new_row.lru[p] = way;
      end
    end
  end

  assign acc_cnt_nxt  = salc_pkg::sat_inc(acc_cnt_r);
  assign hit_cnt_nxt  = hit ? salc_pkg::sat_inc(hit_cnt_r) : hit_cnt_r;
  assign miss_cnt_nxt = hit ? miss_cnt_r : salc_pkg::sat_inc(miss_cnt_r);
  assign wb_cnt_nxt   = wb ? salc_pkg::sat_inc(wb_cnt_r) : wb_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r       <= '0;
      s_vld_r      <= 1'b0;
      s_byp_r      <= 1'b0;
      out_strobe_r <= 1'b0;
      acc_cnt_r    <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      wb_cnt_r     <= '0;
    end else begin
      s_vld_r      <= accept;
      s_byp_r      <= accept && s_vld_r && (in_set == s_set_r);
      out_strobe_r <= s_vld_r;
      if (s_vld_r) begin
        rowv_r[s_set_r] <= 1'b1;
        acc_cnt_r       <= acc_cnt_nxt;
        hit_cnt_r       <= hit_cnt_nxt;
        miss_cnt_r      <= miss_cnt_nxt;
        wb_cnt_r        <= wb_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_wr_r    <= in_mode;
      s_tag_r   <= in_block;
      s_set_r   <= in_set;
      s_rowv_r  <= rowv_r[in_set];
      byp_row_r <= new_row;
    end
    if (s_vld_r) begin
      out_hit_r <= hit;
      out_way_r <= salc_pkg::OUT_WAY_W'(way);
      out_wb_r  <= wb;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_hit             = out_hit_r;
  assign out_way             = out_way_r;
  assign out_writeback       = out_wb_r;
  assign out_access_count    = acc_cnt_r;
  assign out_hit_count       = hit_cnt_r;
  assign out_miss_count      = miss_cnt_r;
  assign out_writeback_count = wb_cnt_r;

  `SALC_CHECK_NEXT(a_strobe_follows_stage, clk, rst_n, s_vld_r, out_strobe_r, "stage word without result strobe")
  `SALC_CHECK(a_hit_no_writeback, clk, rst_n, out_strobe_r, !(out_hit_r && out_wb_r), "hit reported with writeback")
  `SALC_CHECK(a_wb_within_miss, clk, rst_n, 1'b1, wb_cnt_r <= miss_cnt_r, "writeback count above miss count")
  `SALC_CHECK(a_bypass_pair, clk, rst_n, s_byp_r, s_vld_r && $past(s_vld_r), "bypass without back-to-back words")

endmodule

[sv/salc_ram.sv]
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
